>>> rtl/core/pidff_pkg.sv
// Shared types and register indexes for the PID controller with deadband and integral zone.
package pidff_pkg;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Register indexes, in the order of the register map.
  localparam logic [CFG_IDX_W-1:0] REG_KP            = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI            = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD            = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_FORWARD  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ZONE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OUTPUT    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT    = 4'd7;

  // Request operations.
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Reset values of the output limits.
  localparam logic [15:0] MIN_OUTPUT_RESET = 16'h8000;
  localparam logic [15:0] MAX_OUTPUT_RESET = 16'h7FFF;

  // Controller settings as held by the register file (signed fields stored as raw bits).
  typedef struct packed {
    logic [23:0] kp;
    logic [23:0] ki;
    logic [23:0] kd;
    logic [15:0] feed_forward;
    logic [15:0] deadband;
    logic [15:0] integral_zone;
    logic [15:0] min_output;
    logic [15:0] max_output;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [15:0] drive;
    logic [16:0] error_now;
    logic [17:0] error_delta;
    logic        in_deadband;
  } res_t;

endpackage

>>> rtl/core/pid_deadband_izone_ff_unit.sv
// Top level of the PID controller with deadband, integral zone and feed-forward.
// Each request carries a target and a measurement (or a clear command) and yields one result
// that passes through the input register, where the whole PID computation runs, and then the
// result register. A new request is taken every cycle unless the input register is full and
// the result register stalls; the controller state loop closes through the saturating integral
// adder, and the longest path runs from the stored integral through the ki multiplier, the sum
// and the output clamp into the result register. While a result waits, one more request can be
// held in the input register, after which input ready stays low until the result is taken.
// Gains, limits, deadband and integral zone are to be written through the configuration port
// only while no request is in flight; the block itself does not enforce this.
module pid_deadband_izone_ff_unit #(
  parameter int FRAC_BITS = 12,
  parameter int ACC_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidff_pkg::CFG_DATA_W-1:0] cfg_data,
  // Sample requests.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // target[15:0], measured[31:16]
  input  logic [0:0]                      s_axis_tuser,  // op[0]
  // Results.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [55:0]                     m_axis_tdata,  // drive[15:0], error_now[32:16],
                                                         // error_delta[50:33], zero[55:51]
  output logic [0:0]                      m_axis_tuser   // in_deadband[0]
);

  pidff_pkg::cfg_t cfg;
  pidff_pkg::res_t res;

  logic        stage_valid;
  logic        stage_op;
  logic [15:0] stage_target;
  logic [15:0] stage_measured;
  logic        advance;
  logic        step;

  pidff_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline moves when the result register is empty or being emptied.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = stage_valid && advance;
  assign s_axis_tready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_op       <= s_axis_tuser[0];
      stage_target   <= s_axis_tdata[15:0];
      stage_measured <= s_axis_tdata[31:16];
    end
  end

  pidff_calc #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_calc (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .op       (stage_op),
    .target   (stage_target),
    .measured (stage_measured),
    .cfg      (cfg),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {5'd0, res.error_delta, res.error_now, res.drive};
      m_axis_tuser <= res.in_deadband;
    end
  end

  // A result inside the deadband always carries zero drive.
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("deadband result with nonzero drive");

  // A request taken while the stage is full must coincide with the stage moving on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && stage_valid |-> step)
    else $error("input register overwritten");

  // A result waiting to be taken is not replaced.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !stage_valid)
    else $error("pipeline not empty after reset");

endmodule

>>> rtl/core/pidff_cfg.sv
// Configuration register file for the PID controller.
module pidff_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidff_pkg::CFG_DATA_W-1:0] cfg_data,
  output pidff_pkg::cfg_t                 cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp            <= '0;
      cfg.ki            <= '0;
      cfg.kd            <= '0;
      cfg.feed_forward  <= '0;
      cfg.deadband      <= '0;
      cfg.integral_zone <= '0;
      cfg.min_output    <= pidff_pkg::MIN_OUTPUT_RESET;
      cfg.max_output    <= pidff_pkg::MAX_OUTPUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidff_pkg::REG_KP:            cfg.kp            <= cfg_data;
        pidff_pkg::REG_KI:            cfg.ki            <= cfg_data;
        pidff_pkg::REG_KD:            cfg.kd            <= cfg_data;
        pidff_pkg::REG_FEED_FORWARD:  cfg.feed_forward  <= cfg_data[15:0];
        pidff_pkg::REG_DEADBAND:      cfg.deadband      <= cfg_data[15:0];
        pidff_pkg::REG_INTEGRAL_ZONE: cfg.integral_zone <= cfg_data[15:0];
        pidff_pkg::REG_MIN_OUTPUT:    cfg.min_output    <= cfg_data[15:0];
        pidff_pkg::REG_MAX_OUTPUT:    cfg.max_output    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/pidff_calc.sv
// Single-pass PID datapath with the stored error and integral state.
module pidff_calc #(
  parameter int FRAC_BITS = 12,
  parameter int ACC_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            op,
  input  logic [15:0]     target,
  input  logic [15:0]     measured,
  input  pidff_pkg::cfg_t cfg,
  output pidff_pkg::res_t res
);

  localparam int PW = ACC_WIDTH + 24;
  localparam int SW = ((PW > 62) ? PW : 62) + 2;
  localparam logic [SW-1:0] PROD_LIM = {{(SW-61){1'b0}}, 1'b1, 60'd0};
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [16:0]          last_error;
  logic signed [ACC_WIDTH-1:0] integral;

  logic signed [16:0]          err;
  logic signed [17:0]          delta;
  logic        [16:0]          mag;
  logic                        dead;
  logic                        in_zone;
  logic signed [ACC_WIDTH:0]   integ_sum;
  logic signed [ACC_WIDTH-1:0] integ_sat;
  logic signed [ACC_WIDTH-1:0] integ_next;
  logic signed [40:0]          prod_p;
  logic signed [41:0]          prod_d;
  logic signed [PW-1:0]        prod_i;
  logic signed [SW-1:0]        prod_i_ext;
  logic signed [SW-1:0]        prod_i_sat;
  logic signed [SW-1:0]        sum;
  logic signed [SW-1:0]        shifted;
  logic signed [SW-1:0]        ff_mag;
  logic signed [SW-1:0]        with_ff;
  logic signed [SW-1:0]        lo_ext;
  logic signed [SW-1:0]        hi_ext;
  logic signed [SW-1:0]        clamped;

  // Error, its change since the last sample and its magnitude.
  assign err   = 17'($signed(target)) - 17'($signed(measured));
  assign delta = 18'(err) - 18'(last_error);
  assign mag   = err[16] ? 17'(-err) : 17'(err);

  assign dead    = mag <= {1'b0, cfg.deadband};
  assign in_zone = mag <= {1'b0, cfg.integral_zone};

  // Saturating integral update, only outside the deadband and inside the zone.
  assign integ_sum = (ACC_WIDTH+1)'(integral) + (ACC_WIDTH+1)'(err);
  always_comb begin
    if (integ_sum[ACC_WIDTH] != integ_sum[ACC_WIDTH-1]) begin
      integ_sat = integ_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      integ_sat = integ_sum[ACC_WIDTH-1:0];
    end
  end
  assign integ_next = (!dead && in_zone) ? integ_sat : integral;

  // The three gain products; the integral term is limited to plus or minus 2^60.
  assign prod_p     = 41'(err) * 41'($signed(cfg.kp));
  assign prod_d     = 42'(delta) * 42'($signed(cfg.kd));
  assign prod_i     = PW'(integ_next) * PW'($signed(cfg.ki));
  assign prod_i_ext = SW'(prod_i);
  always_comb begin
    if (prod_i_ext > $signed(PROD_LIM)) begin
      prod_i_sat = $signed(PROD_LIM);
    end else if (prod_i_ext < -$signed(PROD_LIM)) begin
      prod_i_sat = -$signed(PROD_LIM);
    end else begin
      prod_i_sat = prod_i_ext;
    end
  end

  // Sum, floor shift to integer units and feed-forward with the drive's sign.
  assign sum     = SW'(prod_p) + SW'(prod_d) + prod_i_sat;
  assign shifted = sum >>> FRAC_BITS;
  assign ff_mag  = cfg.feed_forward[15] ? -SW'($signed(cfg.feed_forward))
                                        : SW'($signed(cfg.feed_forward));
  assign with_ff = shifted[SW-1] ? (shifted - ff_mag) : (shifted + ff_mag);

  // Clamp to the upper bound first, then the lower bound, so the lower one wins.
  assign lo_ext = SW'($signed(cfg.min_output));
  assign hi_ext = SW'($signed(cfg.max_output));
  always_comb begin
    clamped = with_ff;
    if (clamped > hi_ext) begin
      clamped = hi_ext;
    end
    if (clamped < lo_ext) begin
      clamped = lo_ext;
    end
  end

  // Result fields; a clear request reports all zeros.
  always_comb begin
    if (op == pidff_pkg::OP_CLEAR) begin
      res = '0;
    end else begin
      res.drive       = dead ? 16'd0 : clamped[15:0];
      res.error_now   = err;
      res.error_delta = delta;
      res.in_deadband = dead;
    end
  end

  // Controller state advances once per request that leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral   <= '0;
    end else if (step) begin
      if (op == pidff_pkg::OP_CLEAR) begin
        last_error <= '0;
        integral   <= '0;
      end else begin
        last_error <= err;
        integral   <= integ_next;
      end
    end
  end

endmodule
